>>> rtl/rle_mbd_pkg.sv
`timescale 1ns / 1ps

package rle_mbd_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned COUNT_W    = 15;
    localparam int unsigned RUN_LEN_W  = 16;
    localparam int unsigned S_TDATA_W  = 8;
    localparam int unsigned M_TDATA_W  = 24;

    // Count bytes below this value repeat the marker itself.
    localparam logic [BYTE_W-1:0]  MARKER_REPEAT_LIMIT = 8'd3;
    localparam int unsigned        EXT_FLAG_BIT        = 7;
    localparam logic [BYTE_W-1:0]  EXT_HIGH_MASK       = 8'h7f;

endpackage

>>> rtl/rle_marker_byte_decoder_top.sv
`timescale 1ns / 1ps

// Marker-based run-length byte decoder. One compressed byte is taken per
// transfer on the slave side and each decoded run leaves as one transfer on
// the master side carrying the pixel value and run length (1 to 32768).
// The first byte of a stream (tuser high, or the first byte after reset) is
// the marker. The block sustains one byte per clock while the master side
// accepts runs: a byte goes through an input register, then the phase
// logic, then the result register. Bytes that complete no run produce no
// output transfer. Backpressure on the master side stalls the input
// register and, through it, the slave side.
module rle_marker_byte_decoder_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [rle_mbd_pkg::S_TDATA_W-1:0]    s_axis_tdata,  // [7:0] data_byte
    input  logic                                 s_axis_tuser,  // [0] stream_start
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [rle_mbd_pkg::M_TDATA_W-1:0]    m_axis_tdata   // [7:0] pixel_value,
                                                                // [23:8] run_length
);

    import rle_mbd_pkg::*;

    typedef enum logic [2:0] {
        PH_MARKER  = 3'd0,
        PH_SYMBOL  = 3'd1,
        PH_COUNT   = 3'd2,
        PH_LOWBYTE = 3'd3,
        PH_RUNSYM  = 3'd4
    } phase_t;

    logic                  in_valid_reg;
    logic [BYTE_W-1:0]     in_byte_reg;
    logic                  in_start_reg;

    phase_t                phase_reg, phase_next;
    logic [BYTE_W-1:0]     marker_reg, marker_next;
    logic [COUNT_W-1:0]    pending_reg, pending_next;

    logic                  out_valid_reg;
    logic [BYTE_W-1:0]     out_pixel_reg, out_pixel_next;
    logic [RUN_LEN_W-1:0]  out_len_reg, out_len_next;
    logic                  emit;

    logic                  out_free;
    logic                  advance;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_len_reg, out_pixel_reg};

    always_comb
    begin
        phase_next     = phase_reg;
        marker_next    = marker_reg;
        pending_next   = pending_reg;
        emit           = 1'b0;
        out_pixel_next = in_byte_reg;
        out_len_next   = RUN_LEN_W'(1);
        if (in_start_reg || phase_reg == PH_MARKER)
        begin
            marker_next  = in_byte_reg;
            pending_next = '0;
            phase_next   = PH_SYMBOL;
        end
        else
        begin
            case (phase_reg)
                PH_COUNT:
                begin
                    if (in_byte_reg < MARKER_REPEAT_LIMIT)
                    begin
                        phase_next     = PH_SYMBOL;
                        emit           = 1'b1;
                        out_pixel_next = marker_reg;
                        out_len_next   = RUN_LEN_W'(in_byte_reg) + RUN_LEN_W'(1);
                    end
                    else if (in_byte_reg[EXT_FLAG_BIT])
                    begin
                        pending_next = {in_byte_reg[6:0] & EXT_HIGH_MASK[6:0], 8'h00};
                        phase_next   = PH_LOWBYTE;
                    end
                    else
                    begin
                        pending_next = COUNT_W'(in_byte_reg);
                        phase_next   = PH_RUNSYM;
                    end
                end
                PH_LOWBYTE:
                begin
                    pending_next = pending_reg + COUNT_W'(in_byte_reg);
                    phase_next   = PH_RUNSYM;
                end
                PH_RUNSYM:
                begin
                    phase_next   = PH_SYMBOL;
                    emit         = 1'b1;
                    out_len_next = RUN_LEN_W'(pending_reg) + RUN_LEN_W'(1);
                end
                default:
                begin
                    if (in_byte_reg == marker_reg)
                    begin
                        phase_next = PH_COUNT;
                    end
                    else
                    begin
                        phase_next = PH_SYMBOL;
                        emit       = 1'b1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            in_start_reg  <= 1'b0;
            phase_reg     <= PH_MARKER;
            marker_reg    <= '0;
            pending_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
                in_start_reg <= s_axis_tuser;
            end
            if (advance)
            begin
                phase_reg   <= phase_next;
                marker_reg  <= marker_next;
                pending_reg <= pending_next;
            end
            if (out_free)
            begin
                out_valid_reg <= advance && emit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready)
        begin
            in_byte_reg <= s_axis_tdata[BYTE_W-1:0];
        end
        if (advance && emit)
        begin
            out_pixel_reg <= out_pixel_next;
            out_len_reg   <= out_len_next;
        end
    end

`ifndef SYNTH
    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_len_reg != '0 && out_len_reg <= 16'd32768))
        else $error("run length out of range");

    a_start_to_symbol: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_start_reg) |=> (phase_reg == PH_SYMBOL))
        else $error("stream start did not reload marker");

    a_lowbyte_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_LOWBYTE) |-> (pending_reg[7:0] == 8'h00))
        else $error("low byte of pending count not clear");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (in_valid_reg && out_valid_reg && !m_axis_tready))
        else $error("input stalled without cause");
`endif

endmodule

>>> sim/rle_marker_byte_decoder_top_tb.sv
`timescale 1ns / 1ps

module rle_marker_byte_decoder_top_tb;

    import rle_mbd_pkg::*;

    localparam int unsigned QUIET_LIMIT = 2000;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned DRAIN_CYCLES = 20;
    localparam int unsigned RANDOM_BYTES = 550;

    typedef enum logic [2:0] {
        EXPECT_MARKER,
        EXPECT_SYMBOL,
        EXPECT_COUNT,
        EXPECT_LOW,
        EXPECT_RUN_SYM
    } decode_phase_t;

    typedef struct {
        logic [BYTE_W-1:0]    pixel;
        logic [RUN_LEN_W-1:0] len;
    } run_t;

    class rle_run_scoreboard;
        decode_phase_t      phase;
        logic [BYTE_W-1:0]  marker;
        logic [COUNT_W-1:0] count;
        run_t               runs_due[$];
        int unsigned        errors;
        int unsigned        bytes_in;
        int unsigned        runs_ok;
        int unsigned        ext_runs;
        int unsigned        repeat_runs;
        int unsigned        restarts;

        function new();
            phase = EXPECT_MARKER;
            marker = '0;
            count = '0;
            errors = 0;
            bytes_in = 0;
            runs_ok = 0;
            ext_runs = 0;
            repeat_runs = 0;
            restarts = 0;
        endfunction

        function void push_run(logic [BYTE_W-1:0] pixel, logic [RUN_LEN_W-1:0] len);
            run_t r;
            r.pixel = pixel;
            r.len = len;
            runs_due.push_back(r);
        endfunction

        function void take_byte(logic [BYTE_W-1:0] b, logic start);
            bytes_in++;
            if (start || phase == EXPECT_MARKER)
            begin
                if (phase != EXPECT_SYMBOL && phase != EXPECT_MARKER)
                    restarts++;
                marker = b;
                count = '0;
                phase = EXPECT_SYMBOL;
                return;
            end
            case (phase)
                EXPECT_COUNT:
                begin
                    if (b < MARKER_REPEAT_LIMIT)
                    begin
                        push_run(marker, RUN_LEN_W'(b) + 1'b1);
                        repeat_runs++;
                        phase = EXPECT_SYMBOL;
                    end
                    else if (b[EXT_FLAG_BIT])
                    begin
                        count = {b[6:0] & EXT_HIGH_MASK[6:0], 8'h00};
                        phase = EXPECT_LOW;
                    end
                    else
                    begin
                        count = COUNT_W'(b);
                        phase = EXPECT_RUN_SYM;
                    end
                end
                EXPECT_LOW:
                begin
                    count = count + COUNT_W'(b);
                    ext_runs++;
                    phase = EXPECT_RUN_SYM;
                end
                EXPECT_RUN_SYM:
                begin
                    push_run(b, RUN_LEN_W'(count) + 1'b1);
                    phase = EXPECT_SYMBOL;
                end
                default:
                begin
                    if (b == marker)
                        phase = EXPECT_COUNT;
                    else
                    begin
                        push_run(b, 16'd1);
                        phase = EXPECT_SYMBOL;
                    end
                end
            endcase
        endfunction

        function void check_run(logic [M_TDATA_W-1:0] tdata);
            run_t want;
            if (runs_due.size() == 0)
            begin
                $display("%0t: unexpected run, got pixel %02h len %0d",
                         $time, tdata[7:0], tdata[23:8]);
                errors++;
                return;
            end
            want = runs_due.pop_front();
            if (tdata[7:0] !== want.pixel)
            begin
                $display("%0t: pixel mismatch, expected %02h, actual %02h",
                         $time, want.pixel, tdata[7:0]);
                errors++;
            end
            if (tdata[23:8] !== want.len)
            begin
                $display("%0t: run length mismatch, expected %0d, actual %0d",
                         $time, want.len, tdata[23:8]);
                errors++;
            end
            runs_ok++;
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    logic                 s_axis_tuser = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;

    rle_run_scoreboard    run_sb;
    int unsigned          send_idle_pct = 0;
    int unsigned          recv_stall_pct = 0;
    bit                   hold_pending = 1'b0;
    int unsigned          quiet_cycles = 0;
    int unsigned          bytes_sent = 0;
    logic [BYTE_W-1:0]    cur_marker;

    rle_marker_byte_decoder_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 clk = ~clk;

    initial
    begin
        run_sb = new();
    end

    // transfer monitor and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                run_sb.take_byte(s_axis_tdata[7:0], s_axis_tuser);
            if (m_axis_tvalid && m_axis_tready)
                run_sb.check_run(m_axis_tdata);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: watchdog expired, %0d runs still due",
                         $time, run_sb.runs_due.size());
                $display("rle_marker_byte_decoder_top regression: fail");
                $finish;
            end
        end
    end

    // receiver: random stalls, plus one long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_pending)
            begin
                hold_pending = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
            end
            else
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic start);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        s_axis_tuser <= start;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_random_token();
        int unsigned  kind;
        logic [7:0]   b;
        logic         st;
        kind = $urandom_range(99);
        if (kind < 35)
        begin
            b = 8'($urandom);
            if (b == cur_marker)
                b = b ^ 8'h01;
            send_byte(b, 1'b0);
        end
        else if (kind < 50)
        begin
            send_byte(cur_marker, 1'b0);
            send_byte(8'($urandom_range(2)), 1'b0);
        end
        else if (kind < 70)
        begin
            send_byte(cur_marker, 1'b0);
            send_byte(8'($urandom_range(127, 3)), 1'b0);
            send_byte(8'($urandom), 1'b0);
        end
        else if (kind < 82)
        begin
            send_byte(cur_marker, 1'b0);
            send_byte(8'h80 | 8'($urandom_range(127)), 1'b0);
            send_byte(8'($urandom), 1'b0);
            send_byte(8'($urandom), 1'b0);
        end
        else if (kind < 88)
        begin
            cur_marker = 8'($urandom);
            send_byte(cur_marker, 1'b1);
        end
        else if (kind < 94)
        begin
            b = 8'($urandom);
            st = ($urandom_range(15) == 0);
            if (st)
                cur_marker = b;
            send_byte(b, st);
        end
        else
        begin
            send_byte(cur_marker, 1'b0);
            if ($urandom_range(1))
                send_byte(8'($urandom_range(255, 3)), 1'b0);
            if ($urandom_range(1))
                send_byte(8'($urandom), 1'b0);
            cur_marker = 8'($urandom);
            send_byte(cur_marker, 1'b1);
        end
    endtask

    initial
    begin
        int unsigned phase_idx;
        int unsigned stop_at;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: marker without start, literals, marker repeats, short and
        // extended runs, restarts in the middle of a run
        send_byte(8'hA5, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hA5, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hA5, 1'b0);
        send_byte(8'h02, 1'b0);
        send_byte(8'hA5, 1'b0);
        send_byte(8'h03, 1'b0);
        send_byte(8'h5A, 1'b0);
        send_byte(8'hA5, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h02, 1'b0);
        send_byte(8'hC3, 1'b0);
        send_byte(8'hA5, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hA5, 1'b0);
        send_byte(8'hA5, 1'b0);
        send_byte(8'h01, 1'b1);
        send_byte(8'h01, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h01, 1'b0);
        cur_marker = 8'h00;

        for (phase_idx = 0; phase_idx < 4; phase_idx++)
        begin
            case (phase_idx)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 84;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 84;
                end
                default:
                begin
                    send_idle_pct = 19;
                    recv_stall_pct = 19;
                end
            endcase
            if (phase_idx == 0)
                hold_pending = 1'b1;
            stop_at = bytes_sent + RANDOM_BYTES / 4;
            while (bytes_sent < stop_at)
                send_random_token();
        end
        s_axis_tvalid <= 1'b0;
        recv_stall_pct = 0;

        while (run_sb.runs_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d bytes and %0d decoded runs: %0d marker repeats,",
                 run_sb.bytes_in, run_sb.runs_ok, run_sb.repeat_runs);
        $display("%0d extended counts, %0d restarts mid-run, one long output hold-off",
                 run_sb.ext_runs, run_sb.restarts);
        if (run_sb.errors == 0 && run_sb.runs_due.size() == 0)
            $display("rle_marker_byte_decoder_top regression: pass");
        else
            $display("rle_marker_byte_decoder_top regression: fail");
        $finish;
    end

endmodule
